// File: design/lspv_pkg.sv
// Shared types, codes and constants of the looped sample playback voice.
package lspv_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int KIND_W    = 3;
    localparam int ADDR_IN_W = 16;
    localparam int SAMPLE_W  = 16;
    localparam int OFS_W     = 17;
    localparam int LEN_W     = 17;
    localparam int MODE_W    = 2;
    localparam int STEP_W    = 20;
    localparam int CFG_W     = 20;
    localparam int IDX_W     = 3;
    localparam int FRAME_W   = 2 * SAMPLE_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 3'd0,
        KIND_TICK    = 3'd1,
        KIND_NOTE_ON = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_MUTE    = 3'd4,
        KIND_UNMUTE  = 3'd5
    } kind_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SAMPLE_LENGTH = 3'd0,
        REG_LOOP_BEGIN    = 3'd1,
        REG_LOOP_END      = 3'd2,
        REG_LOOP_MODE     = 3'd3,
        REG_SUSTAIN_BEGIN = 3'd4,
        REG_SUSTAIN_END   = 3'd5,
        REG_SUSTAIN_MODE  = 3'd6,
        REG_STEP          = 3'd7
    } cfg_reg_t;

    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd2;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'h10000;

    typedef struct packed {
        logic valid;
        logic active;
    } tick_info_t;

endpackage

// File: design/lspv_store.sv
// Sample frame memory: left and right words side by side, one write and one registered read.
module lspv_store #(
    parameter int ADDR_BITS = lspv_pkg::ADDR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_BITS-1:0]         wr_addr,
    input  logic [lspv_pkg::FRAME_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_BITS-1:0]         rd_addr,
    output logic [lspv_pkg::FRAME_W-1:0] rd_data
);

    logic [lspv_pkg::FRAME_W-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read register only moves on a playing tick, so it holds while its item waits.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/lspv_voice.sv
// Configuration registers, playback position, loop flags and the per-tick position update.
module lspv_voice #(
    parameter int ADDR_BITS = lspv_pkg::ADDR_BITS_DEF,
    parameter int FRAC_BITS = lspv_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [lspv_pkg::IDX_W-1:0]          cfg_index,
    input  logic [lspv_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                accept,
    input  logic [lspv_pkg::KIND_W-1:0]         kind,
    input  logic signed [lspv_pkg::OFS_W-1:0]   pitch_offset,
    output logic                                rd_en,
    output logic [ADDR_BITS-1:0]                rd_addr,
    output lspv_pkg::tick_info_t                tick_info
);

    localparam int PW = ADDR_BITS + FRAC_BITS + 2;
    localparam int IW = ADDR_BITS + 2;
    localparam int BW = FRAC_BITS + lspv_pkg::LEN_W;
    localparam int AW = ((PW > BW) ? PW : BW) + 3;
    localparam int CW = (IW > lspv_pkg::LEN_W) ? IW : lspv_pkg::LEN_W;

    logic [lspv_pkg::LEN_W-1:0]  sample_length_reg;
    logic [lspv_pkg::LEN_W-1:0]  loop_begin_reg;
    logic [lspv_pkg::LEN_W-1:0]  loop_end_reg;
    logic [lspv_pkg::MODE_W-1:0] loop_mode_reg;
    logic [lspv_pkg::LEN_W-1:0]  sustain_begin_reg;
    logic [lspv_pkg::LEN_W-1:0]  sustain_end_reg;
    logic [lspv_pkg::MODE_W-1:0] sustain_mode_reg;
    logic [lspv_pkg::STEP_W-1:0] step_reg;

    logic [PW-1:0] position_reg;
    logic          entered_reg;
    logic          backward_reg;
    logic          held_reg;
    logic          muted_reg;

    logic [PW-1:0] position_next;
    logic          entered_next;
    logic          backward_next;

    logic [IW-1:0]               int_pos;
    logic                        past_end;
    logic                        play;
    logic                        is_tick;
    logic                        use_sustain;
    logic [lspv_pkg::LEN_W-1:0]  sel_begin;
    logic [lspv_pkg::LEN_W-1:0]  sel_end;
    logic [lspv_pkg::MODE_W-1:0] sel_mode;

    logic signed [AW-1:0] p;
    logic signed [AW-1:0] d;
    logic signed [AW-1:0] d2;
    logic signed [AW-1:0] lo;
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] span;
    logic signed [AW-1:0] p_add;
    logic signed [AW-1:0] p_sub;
    logic signed [AW-1:0] p_add2;
    logic signed [AW-1:0] p_sub2;
    logic signed [AW-1:0] p_wrap;
    logic signed [AW-1:0] p_dir;
    logic signed [AW-1:0] r;

    assign int_pos  = position_reg[PW-1:FRAC_BITS];
    assign past_end = CW'(int_pos) >= CW'(sample_length_reg);
    assign play     = !muted_reg && !past_end;
    assign is_tick  = (kind == lspv_pkg::KIND_TICK);

    assign rd_en            = accept && is_tick && play;
    assign rd_addr          = int_pos[ADDR_BITS-1:0];
    assign tick_info.valid  = accept && is_tick;
    assign tick_info.active = play;

    // The sustain loop is active while the note is held and its mode is forward or ping-pong.
    assign use_sustain = held_reg && !sustain_mode_reg[1];
    assign sel_begin   = use_sustain ? sustain_begin_reg : loop_begin_reg;
    assign sel_end     = use_sustain ? sustain_end_reg   : loop_end_reg;
    assign sel_mode    = use_sustain ? sustain_mode_reg  : loop_mode_reg;

    assign p      = $signed(AW'(position_reg));
    assign d      = $signed(AW'(step_reg)) + AW'(pitch_offset);
    assign d2     = d <<< 1;
    assign lo     = $signed(AW'(sel_begin) << FRAC_BITS);
    assign hi     = $signed(AW'(sel_end) << FRAC_BITS);
    assign span   = hi - lo;
    assign p_add  = p + d;
    assign p_sub  = p - d;
    assign p_add2 = p + d2;
    assign p_sub2 = p - d2;
    assign p_wrap = p_add - span;
    assign p_dir  = backward_reg ? p_sub : p_add;

    always_comb
    begin
        r             = p_add;
        entered_next  = entered_reg;
        backward_next = backward_reg;
        if (entered_reg)
        begin
            case (sel_mode)
                lspv_pkg::MODE_FORWARD:
                begin
                    r = (p_add >= hi) ? p_wrap : p_add;
                end
                lspv_pkg::MODE_PINGPONG:
                begin
                    // At the edge ahead, a bounce undoes the crossing step and turns around.
                    if (p_dir >= hi)
                    begin
                        r             = backward_reg ? p_sub2 : p;
                        backward_next = 1'b1;
                    end
                    else if (p_dir <= lo)
                    begin
                        r             = backward_reg ? p : p_add2;
                        backward_next = 1'b0;
                    end
                    else
                    begin
                        r = p_dir;
                    end
                end
                default:
                begin
                    r = p_add;
                end
            endcase
        end
        else
        begin
            entered_next = (p >= lo - d) && (p <= hi + d);
        end

        if (r[AW-1])
        begin
            position_next = '0;
        end
        else if (|r[AW-2:PW])
        begin
            position_next = '1;
        end
        else
        begin
            position_next = r[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_length_reg <= '0;
            loop_begin_reg    <= '0;
            loop_end_reg      <= '0;
            loop_mode_reg     <= lspv_pkg::MODE_OFF;
            sustain_begin_reg <= '0;
            sustain_end_reg   <= '0;
            sustain_mode_reg  <= lspv_pkg::MODE_OFF;
            step_reg          <= lspv_pkg::STEP_RESET;
        end
        else if (cfg_write_en)
        begin
            case (lspv_pkg::cfg_reg_t'(cfg_index))
                lspv_pkg::REG_SAMPLE_LENGTH: sample_length_reg <= cfg_data[lspv_pkg::LEN_W-1:0];
                lspv_pkg::REG_LOOP_BEGIN:    loop_begin_reg    <= cfg_data[lspv_pkg::LEN_W-1:0];
                lspv_pkg::REG_LOOP_END:      loop_end_reg      <= cfg_data[lspv_pkg::LEN_W-1:0];
                lspv_pkg::REG_LOOP_MODE:     loop_mode_reg     <= cfg_data[lspv_pkg::MODE_W-1:0];
                lspv_pkg::REG_SUSTAIN_BEGIN: sustain_begin_reg <= cfg_data[lspv_pkg::LEN_W-1:0];
                lspv_pkg::REG_SUSTAIN_END:   sustain_end_reg   <= cfg_data[lspv_pkg::LEN_W-1:0];
                lspv_pkg::REG_SUSTAIN_MODE:  sustain_mode_reg  <= cfg_data[lspv_pkg::MODE_W-1:0];
                lspv_pkg::REG_STEP:          step_reg          <= cfg_data[lspv_pkg::STEP_W-1:0];
                default:                     step_reg          <= step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            entered_reg  <= 1'b0;
            backward_reg <= 1'b0;
            held_reg     <= 1'b0;
            muted_reg    <= 1'b1;
        end
        else if (accept)
        begin
            case (lspv_pkg::kind_t'(kind))
                lspv_pkg::KIND_TICK:
                begin
                    if (play)
                    begin
                        position_reg <= position_next;
                        entered_reg  <= entered_next;
                        backward_reg <= backward_next;
                    end
                end
                lspv_pkg::KIND_NOTE_ON:
                begin
                    // Restarting a released voice also forgets any loop it had entered.
                    if (!held_reg)
                    begin
                        position_reg <= '0;
                        held_reg     <= 1'b1;
                        entered_reg  <= 1'b0;
                        backward_reg <= 1'b0;
                    end
                end
                lspv_pkg::KIND_RELEASE: held_reg  <= 1'b0;
                lspv_pkg::KIND_MUTE:    muted_reg <= 1'b1;
                lspv_pkg::KIND_UNMUTE:  muted_reg <= 1'b0;
                default:                muted_reg <= muted_reg;
            endcase
        end
    end

endmodule

// File: design/lspv_outq.sv
// Result path: the memory read stage followed by the output register.
module lspv_outq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lspv_pkg::tick_info_t                 tick_info,
    input  logic [lspv_pkg::FRAME_W-1:0]         rd_data,
    input  logic                                 result_ready,
    output logic                                 take_ready,
    output logic                                 result_valid,
    output logic signed [lspv_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [lspv_pkg::SAMPLE_W-1:0] right_sample,
    output logic                                 active
);

    logic s1_valid_reg;
    logic s1_active_reg;
    logic out_valid_reg;
    logic out_active_reg;
    logic signed [lspv_pkg::SAMPLE_W-1:0] left_reg;
    logic signed [lspv_pkg::SAMPLE_W-1:0] right_reg;
    logic s1_move;

    assign s1_move    = !out_valid_reg || result_ready;
    assign take_ready = !s1_valid_reg || s1_move;

    assign result_valid = out_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign active       = out_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_active_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_active_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                out_valid_reg  <= s1_valid_reg;
                out_active_reg <= s1_active_reg;
            end
            if (take_ready)
            begin
                s1_valid_reg  <= tick_info.valid;
                s1_active_reg <= tick_info.active;
            end
        end
    end

    // A silent tick gives zeros instead of the memory word.
    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            left_reg  <= s1_active_reg ? $signed(rd_data[lspv_pkg::FRAME_W-1:lspv_pkg::SAMPLE_W])
                                       : '0;
            right_reg <= s1_active_reg ? $signed(rd_data[lspv_pkg::SAMPLE_W-1:0]) : '0;
        end
    end

endmodule

// File: design/looped_sample_playback_voice_core.sv
// Looped sample playback voice: one sample memory, a position engine and a two-stage result path.
// The voice takes one item per clock while item_ready is high. A load writes a stereo frame, and
// a tick reads the frame at the integer part of the position and moves the position in the same
// cycle, so ticks can follow each other back to back. A tick's result passes through the memory
// read register, which captures the frame when the tick is taken, and then the output register,
// which takes it when it is free. Items are held off only when the read stage and the output
// register both carry a result that has not yet been taken. Sample memory is not cleared after
// reset, and reading a frame that was never loaded gives an arbitrary word.
module looped_sample_playback_voice_core #(
    parameter int ADDR_BITS = lspv_pkg::ADDR_BITS_DEF,
    parameter int FRAC_BITS = lspv_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [lspv_pkg::IDX_W-1:0]           cfg_index,
    input  logic [lspv_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic [lspv_pkg::KIND_W-1:0]          kind,
    input  logic [lspv_pkg::ADDR_IN_W-1:0]       address,
    input  logic signed [lspv_pkg::SAMPLE_W-1:0] left_word,
    input  logic signed [lspv_pkg::SAMPLE_W-1:0] right_word,
    input  logic signed [lspv_pkg::OFS_W-1:0]    pitch_offset,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [lspv_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [lspv_pkg::SAMPLE_W-1:0] right_sample,
    output logic                                 active
);

    logic                         accept;
    logic                         wr_en;
    logic [ADDR_BITS-1:0]         wr_addr;
    logic [lspv_pkg::FRAME_W-1:0] wr_data;
    logic                         rd_en;
    logic [ADDR_BITS-1:0]         rd_addr;
    logic [lspv_pkg::FRAME_W-1:0] rd_data;
    lspv_pkg::tick_info_t         tick_info;

    assign accept  = item_valid && item_ready;
    assign wr_en   = accept && (kind == lspv_pkg::KIND_LOAD);
    assign wr_addr = ADDR_BITS'(address);
    assign wr_data = {left_word, right_word};

    lspv_store #(
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lspv_voice #(
        .ADDR_BITS (ADDR_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_voice (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .kind         (kind),
        .pitch_offset (pitch_offset),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .tick_info    (tick_info)
    );

    lspv_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_info    (tick_info),
        .rd_data      (rd_data),
        .result_ready (result_ready),
        .take_ready   (item_ready),
        .result_valid (result_valid),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .active       (active)
    );

endmodule

// File: design/lspv_checker.sv
// Port-level checks of the voice core and the bind that attaches them.
module lspv_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 item_ready,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic signed [lspv_pkg::SAMPLE_W-1:0] left_sample,
    input logic signed [lspv_pkg::SAMPLE_W-1:0] right_sample,
    input logic                                 active
);

    // A waiting result keeps its values until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(left_sample)
            && $stable(right_sample) && $stable(active))
        else $error("result changed while stalled");

    // A silent tick carries zeros on both channels.
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !active |-> left_sample == '0 && right_sample == '0)
        else $error("silent result carries nonzero samples");

    // Items are only held off while a result is waiting at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with an empty output");

    // Nothing comes out in the cycle right after reset ends.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result presented straight out of reset");

endmodule

bind looped_sample_playback_voice_core lspv_checker u_lspv_checker (.*);
